[hw/rtl/keyed_scatter_accumulate_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the keyed scatter accumulate block
// Shared forms for the concurrent checks of the block, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef KEYED_SCATTER_ACCUMULATE_ASSERT_SVH
`define KEYED_SCATTER_ACCUMULATE_ASSERT_SVH

// Same-cycle implication.
`define KSA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("keyed_scatter_accumulate assertion failed");

// Next-cycle implication.
`define KSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("keyed_scatter_accumulate assertion failed");

`endif

[hw/rtl/ksa_pkg.sv]
// ----------------------------------------------------------------------------
// ksa_pkg
// Types and constants of the keyed scatter accumulate block.
// ----------------------------------------------------------------------------
package ksa_pkg;

  localparam int KEY_W       = 12;
  localparam int COL_W       = 12;
  localparam int WEIGHT_W    = 32;
  localparam int ROW_WIDTH_W = 13;
  localparam int SUM_W       = 48;
  localparam int CALC_ADDR_W = KEY_W + ROW_WIDTH_W + 1;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [1:0] REQ_ACCUM    = 2'd0;
  localparam logic [1:0] REQ_READ     = 2'd1;
  localparam logic [1:0] REQ_READ_CLR = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam logic REG_ROW_WIDTH  = 1'b0;
  localparam logic REG_COUNT_MODE = 1'b1;

  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 13'd1;
  localparam logic signed [WEIGHT_W-1:0] ONE_UNIT = 32'sd65536;

  typedef struct packed {
    logic [1:0]                 req_type;
    logic [KEY_W-1:0]           row_key;
    logic [COL_W-1:0]           col_index;
    logic signed [WEIGHT_W-1:0] weight;
    logic                       batch_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_value;
    logic [1:0]              status;
    logic                    batch_done;
  } out_item_t;

endpackage

[hw/rtl/keyed_scatter_accumulate.sv]
// ----------------------------------------------------------------------------
// keyed_scatter_accumulate
// Group-by sum engine: accumulates weights into a keyed two-dimensional store.
// One item is taken per clock while busy is low. Each item gives one result
// on out_item, marked by out_valid for one cycle; the item is registered in
// s1_v_r and s2_v_r and the result in out_valid_r. The receiver cannot hold
// results off. The rate is set by the accumulator memory, which has one read
// and one write port: an item is read, modified and written back in a
// pipeline, with the last write forwarded to a following item on the same
// entry. After reset the block clears the memory one entry per cycle and
// keeps busy high meanwhile; configuration writes are taken during the clear.
// ----------------------------------------------------------------------------
`include "keyed_scatter_accumulate_assert.svh"

module keyed_scatter_accumulate #(
  parameter int STORE_DEPTH = 4096,
  parameter int ACC_WIDTH   = 48
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  ksa_pkg::in_item_t                  in_item,
  output logic                               out_valid,
  output ksa_pkg::out_item_t                 out_item,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [ksa_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [ksa_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [ksa_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);

  localparam int AddrW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CalcW = ksa_pkg::CALC_ADDR_W;
  localparam int AccW1 = ACC_WIDTH + 1;
  localparam int RowW  = ksa_pkg::ROW_WIDTH_W;
  localparam logic signed [ACC_WIDTH-1:0] AccMax = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] AccMin = ~AccMax;

  logic [RowW-1:0]                 row_width_r;
  logic                            count_mode_r;
  logic                            cfg_wr;
  logic                            cfg_idx;

  logic                            clr_active_r;
  logic [AddrW-1:0]                clr_cnt_r;

  logic                            s1_v_r;
  ksa_pkg::in_item_t               s1_item_r;
  logic [CalcW-1:0]                calc_addr;
  logic                            in_range;

  logic                            s2_v_r;
  logic [1:0]                      s2_req_r;
  logic                            s2_ok_r;
  logic [AddrW-1:0]                s2_addr_r;
  logic signed [ksa_pkg::WEIGHT_W-1:0] s2_weight_r;
  logic                            s2_bend_r;

  logic signed [ACC_WIDTH-1:0]     mem [STORE_DEPTH];
  logic signed [ACC_WIDTH-1:0]     rd_data_r;
  logic                            mem_we;
  logic [AddrW-1:0]                mem_wa;
  logic signed [ACC_WIDTH-1:0]     mem_wd;

  logic                            fwd_v_r;
  logic [AddrW-1:0]                fwd_addr_r;
  logic signed [ACC_WIDTH-1:0]     fwd_data_r;

  logic                            fwd_hit;
  logic signed [ACC_WIDTH-1:0]     entry;
  logic signed [ksa_pkg::WEIGHT_W-1:0] add_val;
  logic signed [AccW1-1:0]         acc_sum;
  logic                            sat;
  logic signed [ACC_WIDTH-1:0]     acc_new;
  logic                            wr_en;
  logic signed [ACC_WIDTH-1:0]     wr_data;

  logic                            out_valid_r;
  ksa_pkg::out_item_t              out_item_r;
  ksa_pkg::out_item_t              out_item_nxt;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r  <= ksa_pkg::ROW_WIDTH_RST;
      count_mode_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        ksa_pkg::REG_ROW_WIDTH:  row_width_r  <= cfg_pwdata[RowW-1:0];
        ksa_pkg::REG_COUNT_MODE: count_mode_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      ksa_pkg::REG_ROW_WIDTH:  cfg_prdata = ksa_pkg::CFG_DATA_W'(row_width_r);
      ksa_pkg::REG_COUNT_MODE: cfg_prdata = ksa_pkg::CFG_DATA_W'(count_mode_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  // Clearing pass after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else if (clr_active_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == AddrW'(STORE_DEPTH - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  assign busy = clr_active_r;

  // Stage 1: address computation and memory read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s1_item_r <= in_item;
    end
  end

  always_comb begin
    calc_addr = CalcW'(s1_item_r.row_key) * CalcW'(row_width_r)
              + CalcW'(s1_item_r.col_index);
    in_range  = (RowW'(s1_item_r.col_index) < row_width_r)
             && (calc_addr < CalcW'(STORE_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_req_r    <= s1_item_r.req_type;
      s2_ok_r     <= in_range;
      s2_addr_r   <= calc_addr[AddrW-1:0];
      s2_weight_r <= s1_item_r.weight;
      s2_bend_r   <= s1_item_r.batch_end;
    end
  end

  // Accumulator memory.
  assign mem_we = wr_en || clr_active_r;
  assign mem_wa = clr_active_r ? clr_cnt_r : s2_addr_r;
  assign mem_wd = clr_active_r ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (s1_v_r) begin
      rd_data_r <= mem[calc_addr[AddrW-1:0]];
    end
  end

  // Stage 2: modify, write back and form the result.
  always_comb begin
    fwd_hit = fwd_v_r && (fwd_addr_r == s2_addr_r);
    entry   = fwd_hit ? fwd_data_r : rd_data_r;
    add_val = count_mode_r ? ksa_pkg::ONE_UNIT : s2_weight_r;
    acc_sum = AccW1'(entry) + AccW1'(add_val);
    sat     = acc_sum[ACC_WIDTH] != acc_sum[ACC_WIDTH-1];
    if (sat) begin
      acc_new = acc_sum[ACC_WIDTH] ? AccMin : AccMax;
    end else begin
      acc_new = acc_sum[ACC_WIDTH-1:0];
    end

    wr_en                   = 1'b0;
    wr_data                 = acc_new;
    out_item_nxt.sum_value  = '0;
    out_item_nxt.status     = ksa_pkg::ST_OK;
    out_item_nxt.batch_done = s2_bend_r;

    priority if (!s2_ok_r) begin
      out_item_nxt.status = ksa_pkg::ST_RANGE;
    end else if (s2_req_r == ksa_pkg::REQ_ACCUM) begin
      wr_en = s2_v_r;
      if (sat) begin
        out_item_nxt.status = ksa_pkg::ST_SAT;
      end
    end else begin
      out_item_nxt.sum_value = 48'(entry);
      if (s2_req_r == ksa_pkg::REQ_READ_CLR) begin
        wr_en   = s2_v_r;
        wr_data = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fwd_v_r     <= wr_en;
      out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r <= s2_addr_r;
    fwd_data_r <= wr_data;
    if (s2_v_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `KSA_ASSERT_IMPL(a_fixed_latency, start && !busy, ##3 out_valid_r)
  `KSA_ASSERT_IMPL(a_clear_alone, clr_active_r, !wr_en && !s2_v_r)
  `KSA_ASSERT_IMPL(a_range_zero, out_valid_r && out_item_r.status == ksa_pkg::ST_RANGE, out_item_r.sum_value == '0)
  `KSA_ASSERT_NEXT(a_sat_accum_only, s2_v_r && s2_ok_r && s2_req_r != ksa_pkg::REQ_ACCUM, out_item_r.status != ksa_pkg::ST_SAT)

endmodule
